[hw/rtl/srbs_pkg.sv]
package srbs_pkg;

  localparam int THR_W      = 11;
  localparam int OUT_W      = 11;
  localparam int SUM_W      = 21;
  localparam int BAND_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_STEP_W = $clog2(SUM_W);

  localparam logic [SUM_W-1:0] SUM_CAP = '1;
  localparam logic [OUT_W-1:0] OUT_CAP = '1;

  localparam logic [BAND_W-1:0] BAND_NORMAL   = 3'd0;
  localparam logic [BAND_W-1:0] BAND_WARNING  = 3'd1;
  localparam logic [BAND_W-1:0] BAND_CRITICAL = 3'd2;
  localparam logic [BAND_W-1:0] BAND_SHUTDOWN = 3'd3;
  localparam logic [BAND_W-1:0] BAND_ERROR    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_WARNING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN = 2'd2;

  localparam logic [THR_W-1:0] WARNING_RESET  = 11'd480;
  localparam logic [THR_W-1:0] CRITICAL_RESET = 11'd720;
  localparam logic [THR_W-1:0] SHUTDOWN_RESET = 11'd960;

  typedef struct packed {
    logic take;
    logic emit_item;
    logic div_start;
    logic emit_summary;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic              summary_valid;
    logic [OUT_W-1:0]  minimum_reading;
    logic [OUT_W-1:0]  maximum_reading;
    logic [OUT_W-1:0]  average_reading;
    logic [OUT_W-1:0]  valid_total;
    logic [OUT_W-1:0]  skipped_total;
    logic [OUT_W-1:0]  normal_total;
    logic [OUT_W-1:0]  warning_total;
    logic [OUT_W-1:0]  critical_total;
    logic [OUT_W-1:0]  shutdown_total;
    logic [OUT_W-1:0]  first_critical_index;
  } result_t;

endpackage

[hw/rtl/srbs_channels.sv]
interface srbs_sample_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          end_of_set;

  modport source(output valid, output sample_value, output end_of_set, input ready);
  modport sink(input valid, input sample_value, input end_of_set, output ready);
endinterface

interface srbs_result_if import srbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BAND_W-1:0] band;
  logic              summary_valid;
  logic [OUT_W-1:0]  minimum_reading;
  logic [OUT_W-1:0]  maximum_reading;
  logic [OUT_W-1:0]  average_reading;
  logic [OUT_W-1:0]  valid_total;
  logic [OUT_W-1:0]  skipped_total;
  logic [OUT_W-1:0]  normal_total;
  logic [OUT_W-1:0]  warning_total;
  logic [OUT_W-1:0]  critical_total;
  logic [OUT_W-1:0]  shutdown_total;
  logic [OUT_W-1:0]  first_critical_index;

  modport source(
    output valid, output band, output summary_valid, output minimum_reading,
    output maximum_reading, output average_reading, output valid_total,
    output skipped_total, output normal_total, output warning_total,
    output critical_total, output shutdown_total, output first_critical_index,
    input ready
  );
  modport sink(
    input valid, input band, input summary_valid, input minimum_reading,
    input maximum_reading, input average_reading, input valid_total,
    input skipped_total, input normal_total, input warning_total,
    input critical_total, input shutdown_total, input first_critical_index,
    output ready
  );
endinterface

[hw/rtl/srbs_ctrl.sv]
module srbs_ctrl import srbs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    end_of_set,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;
  logic       accept;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_RUN) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_RUN: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (end_of_set) begin
            state_next = ST_START;
          end else begin
            cmd.emit_item  = 1'b1;
            out_valid_next = 1'b1;
          end
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit_summary = 1'b1;
          out_valid_next   = 1'b1;
          state_next       = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[hw/rtl/srbs_div.sv]
module srbs_div import srbs_pkg::*; #(
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [SUM_W-1:0] quotient,
  output logic             done
);

  logic                  busy;
  logic [DIV_STEP_W-1:0] step;
  logic [DEN_W:0]        rem;
  logic [DEN_W-1:0]      divisor;
  logic [DEN_W:0]        rem_shift;
  logic [DEN_W:0]        rem_sub;
  logic                  fits;

  assign rem_shift = {rem[DEN_W-1:0], quotient[SUM_W-1]};
  assign fits      = rem_shift >= {1'b0, divisor};
  assign rem_sub   = rem_shift - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= num;
      rem      <= '0;
      divisor  <= den;
    end else if (busy) begin
      rem      <= fits ? rem_sub : rem_shift;
      quotient <= {quotient[SUM_W-2:0], fits};
    end
  end

endmodule

[hw/rtl/srbs_datapath.sv]
module srbs_datapath import srbs_pkg::*; #(
  parameter int SAMPLE_BITS  = 12,
  parameter int MAX_READINGS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [THR_W-1:0]              cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  cmd_t                          cmd,
  output status_t                       status,
  output result_t                       res
);

  localparam int VAL_W = SAMPLE_BITS - 1;
  localparam int CNT_W = $clog2(MAX_READINGS + 1);
  localparam int CMP_W = (VAL_W > THR_W) ? VAL_W : THR_W;
  localparam int ADD_W = ((VAL_W > SUM_W) ? VAL_W : SUM_W) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_READINGS);

  logic [THR_W-1:0] warning_threshold;
  logic [THR_W-1:0] critical_threshold;
  logic [THR_W-1:0] shutdown_threshold;

  logic [VAL_W-1:0]  running_min;
  logic [VAL_W-1:0]  running_max;
  logic [SUM_W-1:0]  running_sum;
  logic [CNT_W-1:0]  valid_count;
  logic [CNT_W-1:0]  skipped_count;
  logic [CNT_W-1:0]  band_counts [4];
  logic [CNT_W-1:0]  item_index;
  logic [CNT_W-1:0]  first_hit_index;
  logic [BAND_W-1:0] last_band;

  logic              negative;
  logic [VAL_W-1:0]  value;
  logic [CMP_W-1:0]  value_cmp;
  logic [BAND_W-1:0] band;
  logic [ADD_W-1:0]  sum_add;
  logic [SUM_W-1:0]  sum_new;
  logic [SUM_W-1:0]  quotient;
  logic [OUT_W-1:0]  average;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c < CNT_MAX) ? c + 1'b1 : CNT_MAX;
  endfunction

  assign negative  = sample_value[SAMPLE_BITS-1];
  assign value     = sample_value[VAL_W-1:0];
  assign value_cmp = CMP_W'(value);

  always_comb begin
    if (negative) begin
      band = BAND_ERROR;
    end else if (value_cmp >= CMP_W'(shutdown_threshold)) begin
      band = BAND_SHUTDOWN;
    end else if (value_cmp >= CMP_W'(critical_threshold)) begin
      band = BAND_CRITICAL;
    end else if (value_cmp >= CMP_W'(warning_threshold)) begin
      band = BAND_WARNING;
    end else begin
      band = BAND_NORMAL;
    end
  end

  assign sum_add = ADD_W'(running_sum) + ADD_W'(value);
  assign sum_new = (sum_add > ADD_W'(SUM_CAP)) ? SUM_CAP : sum_add[SUM_W-1:0];

  srbs_div #(
    .DEN_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num      (running_sum),
    .den      (valid_count),
    .quotient (quotient),
    .done     (status.div_done)
  );

  always_comb begin
    if (valid_count == '0) begin
      average = '0;
    end else if (|quotient[SUM_W-1:OUT_W]) begin
      average = OUT_CAP;
    end else begin
      average = quotient[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warning_threshold  <= WARNING_RESET;
      critical_threshold <= CRITICAL_RESET;
      shutdown_threshold <= SHUTDOWN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WARNING:  warning_threshold  <= cfg_data;
        REG_CRITICAL: critical_threshold <= cfg_data;
        REG_SHUTDOWN: shutdown_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit_summary) begin
      running_min     <= '0;
      running_max     <= '0;
      running_sum     <= '0;
      valid_count     <= '0;
      skipped_count   <= '0;
      item_index      <= '0;
      first_hit_index <= CNT_MAX;
      for (int i = 0; i < 4; i++) begin
        band_counts[i] <= '0;
      end
    end else if (cmd.take) begin
      item_index <= sat_inc(item_index);
      if (negative) begin
        skipped_count <= sat_inc(skipped_count);
      end else begin
        if (valid_count == '0 || value < running_min) begin
          running_min <= value;
        end
        if (valid_count == '0 || value > running_max) begin
          running_max <= value;
        end
        running_sum <= sum_new;
        valid_count <= sat_inc(valid_count);
        for (int i = 0; i < 4; i++) begin
          if (band[1:0] == 2'(i)) begin
            band_counts[i] <= sat_inc(band_counts[i]);
          end
        end
        if ((band == BAND_CRITICAL || band == BAND_SHUTDOWN) &&
            first_hit_index == CNT_MAX && item_index < CNT_MAX) begin
          first_hit_index <= item_index;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      last_band <= band;
    end
    if (cmd.emit_item) begin
      res <= {band, {($bits(result_t) - BAND_W){1'b0}}};
    end else if (cmd.emit_summary) begin
      res.band                 <= last_band;
      res.summary_valid        <= 1'b1;
      res.minimum_reading      <= OUT_W'(running_min);
      res.maximum_reading      <= OUT_W'(running_max);
      res.average_reading      <= average;
      res.valid_total          <= OUT_W'(valid_count);
      res.skipped_total        <= OUT_W'(skipped_count);
      res.normal_total         <= OUT_W'(band_counts[0]);
      res.warning_total        <= OUT_W'(band_counts[1]);
      res.critical_total       <= OUT_W'(band_counts[2]);
      res.shutdown_total       <= OUT_W'(band_counts[3]);
      res.first_critical_index <= OUT_W'(first_hit_index);
    end
  end

endmodule

[hw/rtl/sensor_reading_band_statistics.sv]
// Temperature band statistics. Readings are signed with four fractional bits;
// each one returns a result with its band (normal, warning, critical, shutdown,
// or error for a negative reading) from three threshold registers that the user
// must write on the cfg port only while idle (the block does not enforce this).
// A reading that is not flagged end_of_set is taken every cycle while the
// result side keeps up, and its result is registered at the accepting edge. The
// end_of_set reading has its summary registered once the average is ready and
// the result side is free, and no reading is taken before then: the controller
// steps through start, wait and emit states around a restoring divider that
// produces one quotient bit per cycle over the 21-bit running sum. The summary
// carries min, max, truncated average, saturating counts and the index of the
// first critical-or-above reading (MAX_READINGS when none); state then clears.
module sensor_reading_band_statistics import srbs_pkg::*; #(
  parameter int SAMPLE_BITS  = 12,
  parameter int MAX_READINGS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data,
  srbs_sample_if.sink          samples,
  srbs_result_if.source        results
);

  cmd_t    cmd;
  status_t status;
  result_t res;

  srbs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (samples.valid),
    .end_of_set (samples.end_of_set),
    .in_ready   (samples.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .cmd        (cmd),
    .status     (status)
  );

  srbs_datapath #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_READINGS (MAX_READINGS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_value (samples.sample_value),
    .cmd          (cmd),
    .status       (status),
    .res          (res)
  );

  assign results.band                 = res.band;
  assign results.summary_valid        = res.summary_valid;
  assign results.minimum_reading      = res.minimum_reading;
  assign results.maximum_reading      = res.maximum_reading;
  assign results.average_reading      = res.average_reading;
  assign results.valid_total          = res.valid_total;
  assign results.skipped_total        = res.skipped_total;
  assign results.normal_total         = res.normal_total;
  assign results.warning_total        = res.warning_total;
  assign results.critical_total       = res.critical_total;
  assign results.shutdown_total       = res.shutdown_total;
  assign results.first_critical_index = res.first_critical_index;

endmodule

[hw/rtl/srbs_checker.sv]
module srbs_checker import srbs_pkg::*; #(
  parameter int MAX_READINGS = 1024
) (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             summary_valid,
  input logic [OUT_W-1:0] minimum_reading,
  input logic [OUT_W-1:0] maximum_reading,
  input logic [OUT_W-1:0] average_reading,
  input logic [OUT_W-1:0] valid_total,
  input logic [OUT_W-1:0] skipped_total,
  input logic [OUT_W-1:0] critical_total,
  input logic [OUT_W-1:0] shutdown_total,
  input logic [OUT_W-1:0] first_critical_index
);

  localparam logic [OUT_W-1:0] NO_HIT = OUT_W'(MAX_READINGS);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !summary_valid |->
      valid_total == '0 && skipped_total == '0 && minimum_reading == '0 &&
      average_reading == '0 && first_critical_index == '0)
    else $error("summary fields nonzero on a plain result");

  a_empty_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && summary_valid && valid_total == '0 |->
      minimum_reading == '0 && maximum_reading == '0 && average_reading == '0)
    else $error("empty set reports readings");

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && summary_valid && first_critical_index != NO_HIT |->
      critical_total != '0 || shutdown_total != '0)
    else $error("first critical index without critical readings");

endmodule

bind sensor_reading_band_statistics srbs_checker #(
  .MAX_READINGS(MAX_READINGS)
) u_srbs_checker (
  .clk                  (clk),
  .rst                  (rst),
  .out_valid            (results.valid),
  .out_ready            (results.ready),
  .summary_valid        (results.summary_valid),
  .minimum_reading      (results.minimum_reading),
  .maximum_reading      (results.maximum_reading),
  .average_reading      (results.average_reading),
  .valid_total          (results.valid_total),
  .skipped_total        (results.skipped_total),
  .critical_total       (results.critical_total),
  .shutdown_total       (results.shutdown_total),
  .first_critical_index (results.first_critical_index)
);

[test/tb_sensor_reading_band_statistics.sv]
`timescale 1ns / 100ps

module tb_sensor_reading_band_statistics;
  import srbs_pkg::*;

  localparam int SAMPLE_BITS = 12;
  localparam int MAX_READINGS = 1024;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [THR_W-1:0] cfg_data;

  srbs_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples_ch ();
  srbs_result_if results_ch ();

  sensor_reading_band_statistics #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_READINGS(MAX_READINGS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .samples(samples_ch),
    .results(results_ch)
  );

  logic [THR_W-1:0] thr_warning = WARNING_RESET;
  logic [THR_W-1:0] thr_critical = CRITICAL_RESET;
  logic [THR_W-1:0] thr_shutdown = SHUTDOWN_RESET;

  logic [OUT_W-1:0] low_reading;
  logic [OUT_W-1:0] high_reading;
  logic [SUM_W-1:0] reading_sum;
  logic [OUT_W-1:0] valid_seen;
  logic [OUT_W-1:0] skipped_seen;
  logic [OUT_W-1:0] band_tally [4];
  logic [OUT_W-1:0] reading_pos;
  logic [OUT_W-1:0] first_hot_pos;

  result_t band_reports [$];
  result_t seen_report;
  result_t want_report;

  bit idle_on;
  int stall_left;
  int mismatches;
  int readings_sent;
  int sets_closed;
  int reports_checked;
  int settings_applied;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [OUT_W-1:0] bump(input logic [OUT_W-1:0] c);
    return (c < MAX_READINGS) ? c + 1'b1 : OUT_W'(MAX_READINGS);
  endfunction

  task automatic clear_set_state();
    low_reading = '0;
    high_reading = '0;
    reading_sum = '0;
    valid_seen = '0;
    skipped_seen = '0;
    for (int i = 0; i < 4; i++) band_tally[i] = '0;
    reading_pos = '0;
    first_hot_pos = OUT_W'(MAX_READINGS);
  endtask

  task automatic grade_reading(input logic [SAMPLE_BITS-1:0] raw, input bit last,
                               output result_t r);
    logic [OUT_W-1:0] v;
    logic [BAND_W-1:0] b;
    logic [SUM_W:0] wide;
    logic [SUM_W-1:0] quo;
    r = '0;
    if (raw[SAMPLE_BITS-1]) begin
      b = BAND_ERROR;
      skipped_seen = bump(skipped_seen);
    end else begin
      v = raw[OUT_W-1:0];
      if (v >= thr_shutdown) b = BAND_SHUTDOWN;
      else if (v >= thr_critical) b = BAND_CRITICAL;
      else if (v >= thr_warning) b = BAND_WARNING;
      else b = BAND_NORMAL;
      if (valid_seen == 0) begin
        low_reading = v;
        high_reading = v;
      end else begin
        if (v < low_reading) low_reading = v;
        if (v > high_reading) high_reading = v;
      end
      wide = {1'b0, reading_sum} + (SUM_W + 1)'(v);
      reading_sum = (wide > SUM_CAP) ? SUM_CAP : wide[SUM_W-1:0];
      valid_seen = bump(valid_seen);
      band_tally[b[1:0]] = bump(band_tally[b[1:0]]);
      if ((b == BAND_CRITICAL || b == BAND_SHUTDOWN) && first_hot_pos == MAX_READINGS &&
          reading_pos < MAX_READINGS) begin
        first_hot_pos = reading_pos;
      end
    end
    reading_pos = bump(reading_pos);
    r.band = b;
    if (last) begin
      quo = (valid_seen == 0) ? '0 : reading_sum / SUM_W'(valid_seen);
      r.summary_valid = 1'b1;
      r.minimum_reading = low_reading;
      r.maximum_reading = high_reading;
      r.average_reading = (quo > OUT_CAP) ? OUT_CAP : quo[OUT_W-1:0];
      r.valid_total = valid_seen;
      r.skipped_total = skipped_seen;
      r.normal_total = band_tally[BAND_NORMAL[1:0]];
      r.warning_total = band_tally[BAND_WARNING[1:0]];
      r.critical_total = band_tally[BAND_CRITICAL[1:0]];
      r.shutdown_total = band_tally[BAND_SHUTDOWN[1:0]];
      r.first_critical_index = first_hot_pos;
      clear_set_state();
    end
  endtask

  task automatic send_reading(input logic [SAMPLE_BITS-1:0] raw, input bit last);
    int gap;
    result_t r;
    gap = (idle_on && $urandom_range(0, 15) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      samples_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_ch.valid = 1'b1;
    samples_ch.sample_value = raw;
    samples_ch.end_of_set = last;
    do begin
      @(posedge clk);
    end while (!samples_ch.ready);
    grade_reading(raw, last, r);
    band_reports.push_back(r);
    readings_sent++;
    if (last) sets_closed++;
  endtask

  task automatic drain_reports();
    @(negedge clk);
    samples_ch.valid = 1'b0;
    while (band_reports.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [THR_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_WARNING: thr_warning = data;
      REG_CRITICAL: thr_critical = data;
      REG_SHUTDOWN: thr_shutdown = data;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [THR_W-1:0] w, input logic [THR_W-1:0] c,
                           input logic [THR_W-1:0] s);
    write_threshold(REG_WARNING, w);
    write_threshold(REG_CRITICAL, c);
    write_threshold(REG_SHUTDOWN, s);
    settings_applied++;
  endtask

  task automatic randomize_thresholds();
    int a, b, c, tmp;
    a = $urandom_range(0, 2047);
    b = $urandom_range(0, 2047);
    c = $urandom_range(0, 2047);
    case ($urandom_range(0, 3))
      0: begin
        if (a > b) begin tmp = a; a = b; b = tmp; end
        if (b > c) begin tmp = b; b = c; c = tmp; end
        if (a > b) begin tmp = a; a = b; b = tmp; end
      end
      1: ;
      2: begin
        a = $urandom_range(0, 1) * 2047;
        b = $urandom_range(0, 1) * 2047;
        c = $urandom_range(0, 1) * 2047;
      end
      default: begin
        a = WARNING_RESET;
        b = CRITICAL_RESET;
        c = SHUTDOWN_RESET;
      end
    endcase
    write_all(THR_W'(a), THR_W'(b), THR_W'(c));
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_reading(input bit negative_only);
    int t;
    if (negative_only) return SAMPLE_BITS'($urandom_range(2048, 4095));
    case ($urandom_range(0, 7))
      0: return SAMPLE_BITS'($urandom_range(2048, 4095));
      1: begin
        case ($urandom_range(0, 3))
          0: return 12'h000;
          1: return 12'h7FF;
          2: return 12'hFFF;
          default: return 12'h800;
        endcase
      end
      2, 3, 4, 5: begin
        case ($urandom_range(0, 2))
          0: t = thr_warning;
          1: t = thr_critical;
          default: t = thr_shutdown;
        endcase
        t = t + $urandom_range(0, 4) - 2;
        if (t < 0) t = 0;
        if (t > 2047) t = 2047;
        return SAMPLE_BITS'(t);
      end
      default: return SAMPLE_BITS'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic run_random_sets(input int budget);
    int len, since_cfg;
    bit dark;
    since_cfg = 0;
    while (budget > 0) begin
      if (since_cfg >= 350) begin
        settle();
        randomize_thresholds();
        since_cfg = 0;
      end else if ($urandom_range(0, 19) == 0) begin
        drain_reports();
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      dark = ($urandom_range(0, 15) == 0);
      for (int k = 0; k < len; k++) send_reading(pick_reading(dark), k == len - 1);
      budget -= len;
      since_cfg += len;
    end
  endtask

  task automatic test_default_bands();
    send_reading(0, 1'b0);
    send_reading(479, 1'b0);
    send_reading(480, 1'b0);
    send_reading(719, 1'b0);
    send_reading(720, 1'b0);
    send_reading(959, 1'b0);
    send_reading(960, 1'b0);
    send_reading(2047, 1'b0);
    send_reading(12'hFFF, 1'b0);
    send_reading(12'h800, 1'b1);
    send_reading(12'hFF9, 1'b1);
    send_reading(1000, 1'b1);
  endtask

  task automatic test_threshold_order();
    settle();
    write_all(0, 0, 0);
    send_reading(0, 1'b0);
    send_reading(2047, 1'b1);
    settle();
    write_all(2047, 2047, 2047);
    send_reading(2046, 1'b0);
    send_reading(2047, 1'b1);
    settle();
    write_all(1500, 500, 1000);
    send_reading(400, 1'b0);
    send_reading(500, 1'b0);
    send_reading(999, 1'b0);
    send_reading(1000, 1'b0);
    send_reading(1499, 1'b0);
    send_reading(1500, 1'b1);
    settle();
    write_threshold(REG_UNUSED, 11'd5);
    send_reading(1499, 1'b1);
  endtask

  task automatic test_saturating_set();
    settle();
    write_all(100, 2047, 2047);
    for (int k = 0; k < 1030; k++) begin
      send_reading(SAMPLE_BITS'($urandom_range(2020, 2046)), 1'b0);
    end
    for (int k = 0; k < 10; k++) send_reading(pick_reading(1'b1), 1'b0);
    send_reading(2047, 1'b1);
  endtask

  task automatic test_random_sets();
    settle();
    randomize_thresholds();
    run_random_sets(650);
  endtask

  task automatic test_unpaced();
    settle();
    idle_on = 1'b0;
    write_all(WARNING_RESET, CRITICAL_RESET, SHUTDOWN_RESET);
    run_random_sets(200);
  endtask

  initial begin
    results_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        results_ch.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        results_ch.ready = 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        results_ch.ready = 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready) begin
      seen_report.band = results_ch.band;
      seen_report.summary_valid = results_ch.summary_valid;
      seen_report.minimum_reading = results_ch.minimum_reading;
      seen_report.maximum_reading = results_ch.maximum_reading;
      seen_report.average_reading = results_ch.average_reading;
      seen_report.valid_total = results_ch.valid_total;
      seen_report.skipped_total = results_ch.skipped_total;
      seen_report.normal_total = results_ch.normal_total;
      seen_report.warning_total = results_ch.warning_total;
      seen_report.critical_total = results_ch.critical_total;
      seen_report.shutdown_total = results_ch.shutdown_total;
      seen_report.first_critical_index = results_ch.first_critical_index;
      if (band_reports.size() == 0) begin
        mismatches++;
        $display("%0t: result with none pending, expected nothing actual band %0d",
                 $time, seen_report.band);
      end else begin
        want_report = band_reports.pop_front();
        reports_checked++;
        check_field("band", OUT_W'(want_report.band), OUT_W'(seen_report.band));
        check_field("summary_valid", OUT_W'(want_report.summary_valid),
                    OUT_W'(seen_report.summary_valid));
        check_field("minimum_reading", want_report.minimum_reading,
                    seen_report.minimum_reading);
        check_field("maximum_reading", want_report.maximum_reading,
                    seen_report.maximum_reading);
        check_field("average_reading", want_report.average_reading,
                    seen_report.average_reading);
        check_field("valid_total", want_report.valid_total, seen_report.valid_total);
        check_field("skipped_total", want_report.skipped_total, seen_report.skipped_total);
        check_field("normal_total", want_report.normal_total, seen_report.normal_total);
        check_field("warning_total", want_report.warning_total, seen_report.warning_total);
        check_field("critical_total", want_report.critical_total,
                    seen_report.critical_total);
        check_field("shutdown_total", want_report.shutdown_total,
                    seen_report.shutdown_total);
        check_field("first_critical_index", want_report.first_critical_index,
                    seen_report.first_critical_index);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results pending", $time, QUIET_LIMIT,
             band_reports.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_WARNING;
    cfg_data = '0;
    samples_ch.valid = 1'b0;
    samples_ch.sample_value = '0;
    samples_ch.end_of_set = 1'b0;
    idle_on = 1'b1;
    mismatches = 0;
    readings_sent = 0;
    sets_closed = 0;
    reports_checked = 0;
    settings_applied = 1;
    clear_set_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_bands();
    test_threshold_order();
    test_saturating_set();
    test_random_sets();
    test_unpaced();

    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d readings in %0d sets under %0d threshold settings", readings_sent,
             sets_closed, settings_applied);
    $display("Checked %0d results, including saturated counts and out-of-order thresholds",
             reports_checked);
    if (mismatches == 0 && band_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
